[sv/rsv_pkg.sv]
// rsv_pkg: field widths, reuse-value constants and the command/status structs
// shared by the victim-select controller and datapath. No dependencies.
`default_nettype none

package rsv_pkg;

  // Fixed field widths of the request and result beats
  localparam int SetW = 11;
  localparam int WayW = 4;
  localparam int RndW = 16;

  // Reuse values
  localparam int RvW = 3;
  localparam int RvLevels = 8;                 // number of distinct reuse values
  localparam logic [RvW-1:0] RvHit  = 3'd7;
  localparam logic [RvW-1:0] RvFill = 3'd1;

  // Action codes
  localparam logic ActVictim = 1'b0;
  localparam logic ActUpdate = 1'b1;

  // Remainder unit: quotient bits resolved per cycle
  localparam int DivBits  = 8;
  localparam int DivSteps = RndW / DivBits;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture request beat
    logic clr_wr;    // write one cleared row
    logic rd;        // read the addressed row
    logic upd_wr;    // masked write of one way
    logic calc;      // evaluate row, write back, start remainder
    logic out_load;  // load result register
  } rsv_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_update;
    logic clr_last;
    logic div_done;
    logic out_free;
  } rsv_stat_t;

endpackage

`default_nettype wire

[sv/rsv_req_if.sv]
// rsv_req_if: request channel (valid/ready plus request fields).
// Depends on rsv_pkg.
`default_nettype none

interface rsv_req_if;
  import rsv_pkg::*;

  logic            valid;
  logic            ready;
  logic            action;
  logic [SetW-1:0] set_index;
  logic [WayW-1:0] way_index;
  logic            hit;
  logic            is_writeback;
  logic [RndW-1:0] random_value;

  modport source (
    output valid, action, set_index, way_index, hit, is_writeback, random_value,
    input  ready
  );

  modport sink (
    input  valid, action, set_index, way_index, hit, is_writeback, random_value,
    output ready
  );
endinterface

`default_nettype wire

[sv/rsv_res_if.sv]
// rsv_res_if: result channel (valid/ready plus chosen victim way).
// Depends on rsv_pkg.
`default_nettype none

interface rsv_res_if;
  import rsv_pkg::*;

  logic            valid;
  logic            ready;
  logic [WayW-1:0] victim_way;

  modport source (
    output valid, victim_way,
    input  ready
  );

  modport sink (
    input  valid, victim_way,
    output ready
  );
endinterface

`default_nettype wire

[sv/rsv_div.sv]
// rsv_div: multi-cycle remainder unit, random value mod zero-way count.
// Restoring division, DivBits quotient bits per cycle. Depends on rsv_pkg.
`default_nettype none

module rsv_div #(
  parameter int CW = 5
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  input  wire logic [rsv_pkg::RndW-1:0] dividend,
  input  wire logic [CW-1:0]           divisor,
  output logic                         done,
  output logic [CW-1:0]                rem
);
  import rsv_pkg::*;

  localparam int SCW = (DivSteps > 1) ? $clog2(DivSteps) : 1;

  logic            busy;
  logic [SCW-1:0]  step;
  logic [RndW-1:0] dvd;
  logic [CW-1:0]   dsr;
  logic [RndW-1:0] dvd_next;
  logic [CW-1:0]   rem_next;
  logic [CW:0]     trial;

  // DivBits restoring steps; remainder stays below divisor throughout
  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    trial    = '0;
    for (int i = 0; i < DivBits; i++) begin
      trial    = {rem_next, dvd_next[RndW-1]};
      dvd_next = dvd_next << 1;
      if (trial >= {1'b0, dsr}) begin
        trial = trial - {1'b0, dsr};
      end
      rem_next = trial[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy) begin
      step <= step + SCW'(1);
      if (step == SCW'(DivSteps - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

endmodule

`default_nettype wire

[sv/rsv_dp.sv]
// rsv_dp: datapath - request register, set reduction, reuse-value memory,
// row evaluation, remainder unit, way pick, result register. Uses rsv_pkg, rsv_div.
`default_nettype none

module rsv_dp #(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire rsv_pkg::rsv_cmd_t        cmd,
  output rsv_pkg::rsv_stat_t            stat,
  input  wire logic                     in_action,
  input  wire logic [rsv_pkg::SetW-1:0] in_set_index,
  input  wire logic [rsv_pkg::WayW-1:0] in_way_index,
  input  wire logic                     in_hit,
  input  wire logic                     in_is_writeback,
  input  wire logic [rsv_pkg::RndW-1:0] in_random_value,
  input  wire logic                     res_ready,
  output logic                          res_valid,
  output logic [rsv_pkg::WayW-1:0]      res_way
);
  import rsv_pkg::*;

  localparam int AW        = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int CW        = $clog2(WAYS + 1);
  localparam int RowW      = WAYS * RvW;
  localparam int SplitStep = 6;   // reduction steps from this one up run at capture

  // set_index mod SETS by restoring subtraction of SETS << s, s = hi..lo
  function automatic logic [SetW-1:0] reduce_set(input logic [SetW-1:0] v,
                                                 input int hi, input int lo);
    logic [SetW-1:0] r;
    r = v;
    for (int s = hi; s >= lo; s--) begin
      if (32'(r) >= (32'(SETS) << s)) begin
        r = r - SetW'(32'(SETS) << s);
      end
    end
    return r;
  endfunction

  // Request register
  logic            act_q;
  logic [SetW-1:0] set_q;
  logic [WayW-1:0] way_q;
  logic            hit_q;
  logic            wb_q;
  logic [RndW-1:0] rnd_q;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q <= in_action;
      set_q <= reduce_set(in_set_index, SetW - 1, SplitStep);
      way_q <= in_way_index;
      hit_q <= in_hit;
      wb_q  <= in_is_writeback;
      rnd_q <= in_random_value;
    end
  end

  logic [SetW-1:0] set_r;
  logic [AW-1:0]   row_a;
  logic [AW-1:0]   row_q;

  assign set_r = reduce_set(set_q, SplitStep - 1, 0);
  assign row_a = AW'(set_r);

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      row_q <= row_a;
    end
  end

  // Clear sweep counter
  logic [AW-1:0] clr_cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + AW'(1);
    end
  end

  // Row evaluation
  logic [RowW-1:0]     rd_data;
  logic [RvW-1:0]      rv [WAYS];
  logic [WAYS-1:0]     zm;
  logic [WAYS-1:0]     zm_new;
  logic [RvLevels-1:0] present;
  logic                has_zero;
  logic [RvW-1:0]      min_v;
  logic [RowW-1:0]     norm;
  logic [CW-1:0]       cnt_c;

  always_comb begin
    zm      = '0;
    present = '0;
    for (int w = 0; w < WAYS; w++) begin
      rv[w]          = rd_data[w*RvW +: RvW];
      zm[w]          = (rv[w] == '0);
      present[rv[w]] = 1'b1;
    end
    has_zero = |zm;
    min_v    = '0;
    for (int v = RvLevels - 1; v >= 0; v--) begin
      if (present[v]) begin
        min_v = RvW'(v);
      end
    end
    norm   = '0;
    zm_new = '0;
    cnt_c  = '0;
    for (int w = 0; w < WAYS; w++) begin
      norm[w*RvW +: RvW] = rv[w] - min_v;
      zm_new[w]          = has_zero ? zm[w] : (rv[w] == min_v);
      cnt_c              = cnt_c + CW'(zm_new[w]);
    end
  end

  logic [WAYS-1:0] zmask_q;

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      zmask_q <= zm_new;
    end
  end

  // Update write mask; a way at or beyond WAYS matches nothing
  logic            upd_en;
  logic [WAYS-1:0] upd_mask;
  logic [RvW-1:0]  upd_val;

  assign upd_en  = !(hit_q && wb_q);
  assign upd_val = hit_q ? RvHit : RvFill;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      upd_mask[w] = upd_en && (32'(way_q) == 32'(w));
    end
  end

  // Single write port
  logic            wr_en;
  logic [AW-1:0]   wr_addr;
  logic [WAYS-1:0] wr_mask;
  logic [RowW-1:0] wr_data;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = row_q;
    wr_mask = '1;
    wr_data = norm;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (cmd.upd_wr) begin
      wr_en   = 1'b1;
      wr_addr = row_a;
      wr_mask = upd_mask;
      wr_data = {WAYS{upd_val}};
    end else if (cmd.calc && !has_zero) begin
      wr_en = 1'b1;
    end
  end

  // Reuse-value memory, one row per set
  logic [RowW-1:0] mem [SETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int w = 0; w < WAYS; w++) begin
        if (wr_mask[w]) begin
          mem[wr_addr][w*RvW +: RvW] <= wr_data[w*RvW +: RvW];
        end
      end
    end
    if (cmd.rd) begin
      rd_data <= mem[row_a];
    end
  end

  // Remainder unit
  logic          div_done;
  logic [CW-1:0] rem;

  rsv_div #(
    .CW (CW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.calc),
    .dividend (rnd_q),
    .divisor  (cnt_c),
    .done     (div_done),
    .rem      (rem)
  );

  // Pick the rem-th zero way in way order
  logic [CW-1:0]   pre;
  logic [WayW-1:0] vic;

  always_comb begin
    vic = '0;
    pre = '0;
    for (int w = 0; w < WAYS; w++) begin
      pre = '0;
      for (int j = 0; j < w; j++) begin
        pre = pre + CW'(zmask_q[j]);
      end
      if (zmask_q[w] && (pre == rem)) begin
        vic = WayW'(w);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res_way <= vic;
    end
  end

  always_comb begin
    stat.is_update = (act_q == ActUpdate);
    stat.clr_last  = (clr_cnt == AW'(SETS - 1));
    stat.div_done  = div_done;
    stat.out_free  = !res_valid || res_ready;
  end

endmodule

`default_nettype wire

[sv/rsv_ctrl.sv]
// rsv_ctrl: sequencing state machine for clear sweep, update and victim flow.
// Depends on rsv_pkg.
`default_nettype none

module rsv_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output rsv_pkg::rsv_cmd_t        cmd,
  input  wire rsv_pkg::rsv_stat_t  stat
);
  import rsv_pkg::*;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_READ = 6'b000100,
    S_CALC = 6'b001000,
    S_DIV  = 6'b010000,
    S_PICK = 6'b100000
  } rsv_state_t;

  rsv_state_t state;
  rsv_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        if (stat.is_update) begin
          cmd.upd_wr = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd     = 1'b1;
          state_next = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc   = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (stat.div_done) begin
          state_next = S_PICK;
        end
      end
      S_PICK: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLR;
      end
    endcase
  end

endmodule

`default_nettype wire

[sv/rrip_style_victim_select_core.sv]
// rrip_style_victim_select_core: top level of the 3-bit re-reference victim selector.
// Depends on rsv_pkg, rsv_req_if, rsv_res_if, rsv_ctrl, rsv_dp (and rsv_div).
`default_nettype none

// Keeps a 3-bit reuse value per way of every set (SETS rows of WAYS values
// in one memory). An update beat (action = 1) sets the way to 7 on a hit and
// to 1 on a fill; a writeback hit or a way at or beyond WAYS leaves the state
// alone, and no result beat follows. A victim beat (action = 0) reads the set,
// ages it by its minimum if no way is at zero (writing the set back), and
// returns the (random_value mod zero-count)-th zero way in way order as one
// result beat. set_index is taken mod SETS. After reset the block sweeps the
// memory to zero, one row a cycle, with req.ready low until every row is clear.
// Sequence: an update is captured, then written with its mask. A victim
// request is captured, its row is read, then evaluated and written back; it
// then waits in S_DIV on the remainder unit, which resolves 8 quotient bits
// a cycle and flags done after its last step; the pick then loads its result
// beat once the result register is free.
// One request is in flight at a time; the result register lets the next
// request be taken while a result still waits on res.ready.
module rrip_style_victim_select_core #(
  parameter int SETS = 2048,
  parameter int WAYS = 16
) (
  input wire logic   clk,
  input wire logic   rst,
  rsv_req_if.sink    req,
  rsv_res_if.source  res
);
  import rsv_pkg::*;

  rsv_cmd_t  cmd;
  rsv_stat_t stat;

  // Sequencer
  rsv_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // Memory, evaluation, remainder, pick and result register
  rsv_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .stat            (stat),
    .in_action       (req.action),
    .in_set_index    (req.set_index),
    .in_way_index    (req.way_index),
    .in_hit          (req.hit),
    .in_is_writeback (req.is_writeback),
    .in_random_value (req.random_value),
    .res_ready       (res.ready),
    .res_valid       (res.valid),
    .res_way         (res.victim_way)
  );

  // A result is only loaded when the result register is free
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> stat.out_free)
    else $error("result register overwritten");

  // Clear, update and write-back share one memory write port
  a_one_writer: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clr_wr, cmd.upd_wr, cmd.calc}))
    else $error("two writers on memory port");

  // A result beat only appears after a pick
  a_res_src: assert property (@(posedge clk) disable iff (rst)
    $rose(res.valid) |-> $past(cmd.out_load))
    else $error("result beat without pick");

endmodule

`default_nettype wire
